// ===== rtl/lrukv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lrukv_pkg;

  // Default number of cells in the recency chain
  localparam int unsigned ENTRIES_DEF = 8;

  // Capacity register width and reset value
  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  // Request action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // One request
  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  // One response
  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } rsp_t;

  // Contents of one cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic signed [31:0] data;
  } entry_t;

  // Control broadcast to every cell for one accepted request
  typedef struct packed {
    logic advance;  // the chain moves for this request
    logic insert;   // miss on a put: every cell moves down one
    logic put;      // accepted put: evict cells beyond capacity
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lrukv_cell.sv =====
// One cell of the recency chain: holds one entry and passes it down on promotion.
`default_nettype none

module lrukv_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lrukv_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                keep_i,
  input  wire logic signed [31:0]  key_i,
  input  wire lrukv_pkg::entry_t   prev_i,
  input  wire logic                suffix_i,
  output lrukv_pkg::entry_t        entry_o,
  output logic                     suffix_o,
  output logic signed [31:0]       hit_data_o
);

  logic               valid_q, valid_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] data_q, data_d;
  logic               match;
  logic               load;

  // Compare the request key against this cell
  assign match      = valid_q && (key_q == key_i);
  assign suffix_o   = match || suffix_i;
  assign hit_data_o = match ? data_q : 32'sd0;

  // Take the upper neighbour's entry when the hit lies at or below this cell, or on an insert
  assign load = ctrl_i.advance && (ctrl_i.insert || suffix_o);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    if (load) begin
      valid_d = prev_i.valid;
      key_d   = prev_i.key;
      data_d  = prev_i.data;
    end
    // Drop entries beyond the capacity after every put
    if (ctrl_i.put && !keep_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.data  = data_q;

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key-value cache.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------
//   in      | request   | in_valid_i / in_ready_o   | in_req_i  (req_t)
//   out     | response  | out_valid_o / out_ready_i | out_rsp_o (rsp_t)
//   cfg     | write     | cfg_valid_i / cfg_ready_o | cfg_data_i (capacity)
//
// One request per cycle; its response is registered and shows in the cycle after
// acceptance. The cells form a chain ordered by recency, cell 0 most recent, so
// lookup, promotion and eviction complete in the cycle of acceptance.
// A new request is taken whenever the response register is empty or drains.
// Reset empties every cell and sets the capacity to eight; no clearing pass.
`default_nettype none

module lru_key_value_cache_top #(
  parameter int unsigned Entries = lrukv_pkg::ENTRIES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire lrukv_pkg::req_t              in_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output lrukv_pkg::rsp_t                   out_rsp_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [lrukv_pkg::CFG_W-1:0]  cfg_data_i
);

  logic [lrukv_pkg::CFG_W-1:0] active_q;
  logic                        out_valid_q;
  lrukv_pkg::rsp_t             out_rsp_q;
  lrukv_pkg::rsp_t             rsp_d;
  lrukv_pkg::cell_ctrl_t       ctrl;
  lrukv_pkg::entry_t           head;
  lrukv_pkg::entry_t           entry [Entries];
  logic                        suffix [Entries+1];
  logic signed [31:0]          hit_data [Entries];
  logic [Entries-1:0]          keep;
  logic signed [31:0]          hit_value;
  logic                        accept;
  logic                        hit;
  logic                        is_put;

  // Capacity register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= lrukv_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  // Accept while the response register is free or being taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_put     = (in_req_i.action == lrukv_pkg::ACT_PUT);
  assign hit        = suffix[0];

  assign ctrl.advance = accept && (hit || is_put);
  assign ctrl.insert  = accept && is_put && !hit;
  assign ctrl.put     = accept && is_put;

  // Gather the stored value of the matching cell (at most one matches)
  always_comb begin
    hit_value = 32'sd0;
    for (int i = 0; i < int'(Entries); i++) begin
      hit_value = hit_value | hit_data[i];
    end
  end

  // Entry written into the most recent cell
  assign head.valid = 1'b1;
  assign head.key   = in_req_i.key;
  assign head.data  = is_put ? in_req_i.value : hit_value;

  assign suffix[Entries] = 1'b0;

  // Build the recency chain
  for (genvar i = 0; i < int'(Entries); i++) begin : g_cell
    // Cell 0 always survives; a zero capacity acts as one
    assign keep[i] = (i == 0) || (32'(i) < 32'(active_q));

    lrukv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .keep_i     (keep[i]),
      .key_i      (in_req_i.key),
      .prev_i     ((i == 0) ? head : entry[(i == 0) ? 0 : i-1]),
      .suffix_i   (suffix[i+1]),
      .entry_o    (entry[i]),
      .suffix_o   (suffix[i]),
      .hit_data_o (hit_data[i])
    );
  end

  // Response for the accepted request
  assign rsp_d.hit        = hit;
  assign rsp_d.read_value = (hit && !is_put) ? hit_value : 32'sd0;

  // Hold the response until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ===== rtl/lrukv_checker.sv =====
// Port-level assertions for the LRU key-value cache, bound to the top level.
`default_nettype none

module lrukv_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire lrukv_pkg::req_t             in_req_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire lrukv_pkg::rsp_t             out_rsp_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // A stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // Every accepted request shows its response in the next cycle
  a_rsp_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("response missing after accepted request");

  // A put never returns data
  a_put_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_req_i.action == lrukv_pkg::ACT_PUT) |=> out_rsp_o.read_value == 32'sd0)
    else $error("put returned a value");

  // A get straight after a put of the same key hits with the value written
  a_put_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 (in_acc && $past(in_req_i.action) == lrukv_pkg::ACT_PUT
                && in_req_i.action == lrukv_pkg::ACT_GET
                && in_req_i.key == $past(in_req_i.key))
    |=> out_rsp_o.hit && out_rsp_o.read_value == $past(in_req_i.value, 2))
    else $error("get after put of same key missed or returned wrong data");

  // Requests stall only while a response waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("request stalled with empty response register");

endmodule

bind lru_key_value_cache_top lrukv_checker u_lrukv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

// ===== verif/lru_key_value_cache_top_tb.sv =====
// Testbench for the LRU key-value cache: random handshake driver, checking monitor, recency model.
module lru_key_value_cache_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 9;
  localparam int REQS_PER_PHASE = 72;

  // One cached key with its data, kept in recency order by the model
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] data;
  } kv_pair_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  lrukv_pkg::req_t             in_req_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  lrukv_pkg::rsp_t             out_rsp_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [lrukv_pkg::CFG_W-1:0] cfg_data_i = '0;

  // Model state: most recent entry at the front
  kv_pair_t                    lru_order[$];
  logic [lrukv_pkg::CFG_W-1:0] capacity_reg = lrukv_pkg::ACTIVE_RESET;

  lrukv_pkg::req_t pending_reqs[$];
  lrukv_pkg::rsp_t expected_rsps[$];

  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  bit  in_accepted = 1'b0;
  int  reqs_queued = 0;
  int  reqs_accepted = 0;
  int  error_count = 0;
  int  cycle_count = 0;

  lru_key_value_cache_top #(
    .Entries(lrukv_pkg::ENTRIES_DEF)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Number of entries kept after a put; out-of-range settings are clamped
  function automatic int live_capacity();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > lrukv_pkg::ENTRIES_DEF) return int'(lrukv_pkg::ENTRIES_DEF);
    return int'(capacity_reg);
  endfunction

  // Apply one request to the recency model and return the response it should produce
  function automatic lrukv_pkg::rsp_t access_cache(lrukv_pkg::req_t r);
    lrukv_pkg::rsp_t rsp;
    int              found;
    kv_pair_t        hit_line;
    found = -1;
    foreach (lru_order[i]) begin
      if (lru_order[i].key == r.key) found = i;
    end
    rsp.hit = (found >= 0);
    rsp.read_value = '0;
    if (found >= 0) begin
      // Hit: move the entry to the front, refreshing its data on a put
      hit_line = lru_order[found];
      lru_order.delete(found);
      if (r.action == lrukv_pkg::ACT_PUT) hit_line.data = r.value;
      else rsp.read_value = hit_line.data;
      lru_order.push_front(hit_line);
    end else if (r.action == lrukv_pkg::ACT_PUT) begin
      // Miss on a put: reuse the least recent slot when the store is full
      if (lru_order.size() == lrukv_pkg::ENTRIES_DEF) void'(lru_order.pop_back());
      hit_line.key = r.key;
      hit_line.data = r.value;
      lru_order.push_front(hit_line);
    end
    // Every put trims the store down to the live capacity
    if (r.action == lrukv_pkg::ACT_PUT) begin
      while (lru_order.size() > live_capacity()) void'(lru_order.pop_back());
    end
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic queue_req(input logic act, input logic [31:0] k, input logic [31:0] v);
    lrukv_pkg::req_t r;
    r.action = act;
    r.key = k;
    r.value = v;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Random request: keys mostly from a small pool sized to the capacity so that hits occur
  task automatic queue_random_req();
    int          span;
    int          idx;
    logic [31:0] k;
    logic [31:0] v;
    span = live_capacity() + 3;
    if (span > 11) span = 11;
    idx = $urandom_range(span, 0);
    case (idx)
      0:       k = 32'h8000_0000;
      1:       k = 32'h7fff_ffff;
      2:       k = 32'h0000_0000;
      3:       k = 32'hffff_ffff;
      default: k = 32'h00a5_0000 + idx;
    endcase
    if ($urandom_range(99, 0) < 15) k = $urandom;
    case ($urandom_range(9, 0))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = 32'h0000_0000;
      3:       v = 32'hffff_ffff;
      default: v = $urandom;
    endcase
    queue_req($urandom_range(1, 0) ? lrukv_pkg::ACT_PUT : lrukv_pkg::ACT_GET, k, v);
  endtask

  // Hold until every queued request is accepted and answered
  task automatic wait_drained();
    do @(negedge clk_i);
    while (reqs_accepted != reqs_queued || expected_rsps.size() != 0);
  endtask

  task automatic write_capacity(input logic [lrukv_pkg::CFG_W-1:0] cap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    capacity_reg = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver: present the next pending request once the previous one is taken
  always @(negedge clk_i) begin : req_driver
    if (!in_valid_i || in_accepted) begin
      if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= in_idle_pct) begin
        in_req_i <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99, 0) >= out_stall_pct);
  end

  // Monitor: check responses against the model, then predict for a newly accepted request
  always @(posedge clk_i) begin : rsp_monitor
    lrukv_pkg::rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("unexpected response hit=%0b read_value=%0d",
                                    out_rsp_o.hit, out_rsp_o.read_value));
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp_o.hit !== want.hit)
            report_mismatch($sformatf("hit got %0b want %0b", out_rsp_o.hit, want.hit));
          if (out_rsp_o.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      out_rsp_o.read_value, want.read_value));
        end
      end
      in_accepted = in_valid_i && in_ready_o;
      if (in_accepted) begin
        expected_rsps.push_back(access_cache(in_req_i));
        reqs_accepted++;
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_rsps.size());
      $display("** lru_key_value_cache_top: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [lrukv_pkg::CFG_W-1:0] phase_caps [RANDOM_PHASES];
    phase_caps = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd1, 4'd5, 4'd4, 4'd7, 4'd3};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    in_idle_pct = 7;
    out_stall_pct = 56;

    // Directed: empty lookup, field extremes, update of a live key, overflow of a full store
    queue_req(lrukv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lrukv_pkg::ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(lrukv_pkg::ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(lrukv_pkg::ACT_PUT, 32'h0000_0000, 32'hffff_ffff);
    queue_req(lrukv_pkg::ACT_PUT, 32'hffff_ffff, 32'h0000_0000);
    queue_req(lrukv_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(lrukv_pkg::ACT_PUT, 32'h0000_0000, 32'h1234_5678);
    queue_req(lrukv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
    for (int k = 1; k <= 5; k++) queue_req(lrukv_pkg::ACT_PUT, k, 32'h5a5a_0000 + k);
    queue_req(lrukv_pkg::ACT_GET, 32'h7fff_ffff, 32'h0000_0000);
    queue_req(lrukv_pkg::ACT_GET, 32'hffff_ffff, 32'hdead_beef);
    queue_req(lrukv_pkg::ACT_GET, 32'h0000_0003, 32'hffff_ffff);
    wait_drained();

    // Lowered capacity: entries beyond it survive until the next put
    write_capacity(4'd3);
    queue_req(lrukv_pkg::ACT_GET, 32'h0000_0001, 32'h0000_0000);
    queue_req(lrukv_pkg::ACT_PUT, 32'h0000_0006, 32'h0bad_cafe);
    queue_req(lrukv_pkg::ACT_GET, 32'h0000_0002, 32'h0000_0000);
    queue_req(lrukv_pkg::ACT_GET, 32'h0000_0001, 32'h0000_0000);
    queue_req(lrukv_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);
    wait_drained();

    // Random phases over a spread of capacity settings and idling patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p / 3)
        0: begin
          in_idle_pct = 7;
          out_stall_pct = 56;
        end
        1: begin
          in_idle_pct = 56;
          out_stall_pct = 7;
        end
        default: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
      endcase
      write_capacity(phase_caps[p]);
      for (int n = 0; n < REQS_PER_PHASE; n++) queue_random_req();
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** lru_key_value_cache_top: PASSED **");
    end else begin
      $display("** lru_key_value_cache_top: FAILED **");
    end
    $finish;
  end

endmodule
